### src/lsc_pkg.sv
// shared types, codes and helper functions for the lift servo cycle sequencer
`timescale 1ns / 1ps
`default_nettype none
package lsc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DOWN     = 3'd1,
        PH_UP       = 3'd2,
        PH_DWELL    = 3'd3,
        PH_FINAL    = 3'd4,
        PH_STOPPING = 3'd5,
        PH_COMPLETE = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_DOWN = 2'd1,
        DIR_UP   = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_COMPLETE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_DWELL_MS   = 2'd0,
        REG_MOTOR_DUTY = 2'd1,
        REG_HOME_ANGLE = 2'd2
    } reg_index_t;

    localparam logic [7:0] CMD_START   = 8'd1;
    localparam logic [7:0] CMD_STOP    = 8'd2;
    localparam logic [7:0] ANGLE_LIMIT = 8'd180;

    localparam logic [15:0] DWELL_MS_RESET   = 16'd1000;
    localparam logic [7:0]  MOTOR_DUTY_RESET = 8'd200;
    localparam logic [7:0]  HOME_ANGLE_RESET = 8'd0;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_DATA_W  = 16;

    typedef struct packed {
        logic        ms_tick;
        logic        upper_hit;
        logic        lower_hit;
        logic [7:0]  cmd_byte;
        logic        cmd_valid;
    } in_item_t;

    typedef struct packed {
        phase_t      phase_now;
        status_t     status_code;
        logic        status_valid;
        logic        busy_led;
        logic [7:0]  servo_angle;
        logic [7:0]  pwm_duty;
        dir_t        motor_dir;
    } out_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  cycle_no;
        logic [15:0] dwell_count;
        logic [7:0]  angle;
        logic        led;
    } seq_state_t;

    typedef struct packed {
        logic [15:0] dwell_ms;
        logic [7:0]  motor_duty;
        logic [7:0]  home_angle;
    } seq_cfg_t;

    function automatic logic [7:0] home_value(input logic [7:0] home_angle);
        return (home_angle > ANGLE_LIMIT) ? ANGLE_LIMIT : home_angle;
    endfunction

    // servo angle for a cycle number: 30 degrees per cycle, home outside 1..6
    function automatic logic [7:0] cycle_angle(input logic [2:0] n,
                                               input logic [7:0] home_angle);
        logic [7:0] a;
        case (n)
            3'd1: a = 8'd30;
            3'd2: a = 8'd60;
            3'd3: a = 8'd90;
            3'd4: a = 8'd120;
            3'd5: a = 8'd150;
            3'd6: a = 8'd180;
            default: a = home_value(home_angle);
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

### src/lsc_step.sv
// next-state and result logic for one sample period of the sequencer
`timescale 1ns / 1ps
`default_nettype none
module lsc_step #(
    parameter int NUM_CYCLES = 6
) (
    input  var lsc_pkg::in_item_t   item,
    input  var lsc_pkg::seq_state_t cur,
    input  var lsc_pkg::seq_cfg_t   cfg,
    output lsc_pkg::seq_state_t     nxt,
    output lsc_pkg::out_item_t      res
);
    import lsc_pkg::*;

    localparam logic [2:0] LAST_CYCLE = 3'(NUM_CYCLES);

    logic  stop_cmd;
    logic  start_cmd;
    dir_t  dir;
    logic  sv;
    status_t sc;

    assign stop_cmd  = item.cmd_valid && (item.cmd_byte == CMD_STOP);
    assign start_cmd = item.cmd_valid && (item.cmd_byte == CMD_START);

    always_comb begin
        nxt = cur;
        dir = DIR_STOP;
        sv  = 1'b0;
        sc  = ST_IDLE;
        case (cur.phase)
            PH_IDLE: begin
                if (!item.cmd_valid) begin
                    sv = 1'b1;
                end else if (start_cmd) begin
                    nxt.led   = 1'b1;
                    nxt.phase = PH_DOWN;
                end
            end
            PH_DOWN, PH_UP, PH_DWELL, PH_FINAL: begin
                if (!item.cmd_valid) begin
                    sv = 1'b1;
                    sc = ST_RUNNING;
                end
                if (stop_cmd) begin
                    nxt.phase = PH_STOPPING;
                end else if (cur.phase == PH_DOWN) begin
                    if (item.lower_hit) begin
                        nxt.angle = cycle_angle(cur.cycle_no, cfg.home_angle);
                        nxt.phase = PH_UP;
                    end else begin
                        dir = DIR_DOWN;
                    end
                end else if (cur.phase == PH_UP) begin
                    if (item.upper_hit) begin
                        nxt.dwell_count = '0;
                        nxt.phase       = PH_DWELL;
                    end else begin
                        dir = DIR_UP;
                    end
                end else if (cur.phase == PH_DWELL) begin
                    if (item.ms_tick) begin
                        if (cur.dwell_count >= cfg.dwell_ms) begin
                            if (cur.cycle_no >= LAST_CYCLE) begin
                                nxt.phase = PH_FINAL;
                            end else begin
                                nxt.cycle_no = cur.cycle_no + 3'd1;
                                nxt.phase    = PH_DOWN;
                            end
                        end else begin
                            nxt.dwell_count = cur.dwell_count + 16'd1;
                        end
                    end
                end else begin
                    if (item.lower_hit) begin
                        nxt.angle = home_value(cfg.home_angle);
                        nxt.phase = PH_COMPLETE;
                    end else begin
                        dir = DIR_DOWN;
                    end
                end
            end
            PH_STOPPING: begin
                nxt.led = 1'b0;
                if (item.lower_hit) begin
                    nxt.angle = home_value(cfg.home_angle);
                    nxt.phase = PH_IDLE;
                end else begin
                    dir = DIR_DOWN;
                end
            end
            PH_COMPLETE: begin
                sv           = 1'b1;
                sc           = ST_COMPLETE;
                nxt.cycle_no = 3'd1;
                nxt.led      = 1'b0;
                nxt.phase    = PH_IDLE;
            end
            default: begin
                nxt.phase = PH_IDLE;
            end
        endcase

        res.motor_dir    = dir;
        res.pwm_duty     = (dir != DIR_STOP) ? cfg.motor_duty : 8'd0;
        res.servo_angle  = nxt.angle;
        res.busy_led     = nxt.led;
        res.status_valid = sv;
        res.status_code  = sc;
        res.phase_now    = nxt.phase;
    end

endmodule
`default_nettype wire

### src/lift_servo_cycle_sequencer.sv
// top level: input register, sequencer state, result register and config registers
`timescale 1ns / 1ps
`default_nettype none
// Lift servo cycle sequencer. Each input item is one sample period (command byte,
// limit switches, millisecond tick) and produces exactly one result item with motor
// drive, servo angle, busy led, status report and current phase. An item passes an
// input register and then one stage of next-state logic into the result register:
// m_tvalid rises once the item has moved from the input register into the result
// register, and one item is taken every cycle as long as the result side keeps up.
// The result register holds while m_tready is low, and s_tready then drops once the
// input register is full.
// Configuration (dwell, pwm duty, home angle) is written through cfg_wr_en and
// should change only while no item is in flight.
module lift_servo_cycle_sequencer #(
    parameter int NUM_CYCLES = 6
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // cmd_valid, cmd_byte[7:0], lower_hit, upper_hit, ms_tick, zero pad
    input  wire  [lsc_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // motor_dir[1:0], pwm_duty[7:0], servo_angle[7:0], busy_led, status_valid,
    // status_code[1:0], phase_now[2:0], zero pad
    output logic [lsc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  wire                                cfg_wr_en,
    input  wire  [1:0]                         cfg_index,
    input  wire  [lsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lsc_pkg::*;

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       advance;
    seq_state_t state_reg;
    seq_state_t state_next;
    seq_cfg_t   cfg_reg;
    out_item_t  res_next;
    out_item_t  out_reg;
    logic       out_valid_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(out_item_t)){1'b0}}, out_reg};

    lsc_step #(
        .NUM_CYCLES (NUM_CYCLES)
    ) u_step (
        .item (in_item_reg),
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            state_reg.phase      <= PH_IDLE;
            state_reg.cycle_no   <= 3'd1;
            state_reg.dwell_count <= '0;
            state_reg.angle      <= home_value(HOME_ANGLE_RESET);
            state_reg.led        <= 1'b0;
            cfg_reg.dwell_ms     <= DWELL_MS_RESET;
            cfg_reg.motor_duty   <= MOTOR_DUTY_RESET;
            cfg_reg.home_angle   <= HOME_ANGLE_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_item_reg  <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                state_reg     <= state_next;
                out_reg       <= res_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                case (reg_index_t'(cfg_index))
                    REG_DWELL_MS:   cfg_reg.dwell_ms   <= cfg_data;
                    REG_MOTOR_DUTY: cfg_reg.motor_duty <= cfg_data[7:0];
                    REG_HOME_ANGLE: cfg_reg.home_angle <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // a stopped motor never carries a duty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.motor_dir == DIR_STOP) |-> (out_reg.pwm_duty == 8'd0))
        else $error("pwm duty nonzero with motor stopped");

    // a status code other than idle only comes with a report
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.status_code != ST_IDLE) |-> out_reg.status_valid)
        else $error("status code without status report");

    // cycle number stays within 1..NUM_CYCLES
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.cycle_no != 3'd0) && (state_reg.cycle_no <= 3'(NUM_CYCLES)))
        else $error("cycle number out of range");

    // a newly registered result reflects the state the sequencer just moved into
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(advance) |-> (out_reg.phase_now == state_reg.phase
                            && out_reg.busy_led == state_reg.led))
        else $error("result does not match sequencer state");

endmodule
`default_nettype wire

### tb/sv/lift_servo_cycle_sequencer_tb.sv
// stream testbench for the lift servo cycle sequencer with its own sequencer predictor
`timescale 1ns / 1ps
module lift_servo_cycle_sequencer_tb;
    import lsc_pkg::*;

    localparam int SEQ_CYCLES  = 6;
    localparam int STEP_DEG    = 30;
    localparam int CYCLE_LIMIT = 500000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // cmd_valid, cmd_byte[7:0], lower_hit, upper_hit, ms_tick, zero pad
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // motor_dir[1:0], pwm_duty[7:0], servo_angle[7:0], busy_led, status_valid,
    // status_code[1:0], phase_now[2:0], zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    lift_servo_cycle_sequencer #(.NUM_CYCLES(SEQ_CYCLES)) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // predictor copy of the sequencer state and registers
    phase_t      ph  = PH_IDLE;
    logic [2:0]  cyc = 3'd1;
    logic [15:0] dwc = 16'd0;
    logic [7:0]  ang = HOME_ANGLE_RESET;
    logic        led = 1'b0;
    logic [15:0] c_dwell = DWELL_MS_RESET;
    logic [7:0]  c_duty  = MOTOR_DUTY_RESET;
    logic [7:0]  c_home  = HOME_ANGLE_RESET;

    in_item_t  sample_q[$];
    out_item_t report_q[$];
    in_item_t  cur_sample;
    out_item_t got, want;

    int  send_wait = 0;
    int  recv_wait = 0;
    bit  calm = 1'b0;
    int  fail_count = 0;
    int  samples_sent = 0;
    int  reports_seen = 0;
    int  runs_done = 0;
    int  stops_taken = 0;
    int  settings_used = 0;
    int  cycle_count = 0;

    function automatic logic [7:0] home_clip();
        return (c_home > ANGLE_LIMIT) ? ANGLE_LIMIT : c_home;
    endfunction

    function automatic logic [7:0] cycle_deg(logic [2:0] n);
        if (n >= 3'd1 && n <= 3'd6)
            return 8'(STEP_DEG * n);
        return home_clip();
    endfunction

    // one sample period of the sequencer: updates the state, returns the report
    function automatic out_item_t advance_sequencer(in_item_t it);
        dir_t      dir;
        status_t   sc;
        logic      sv;
        logic      stop_cmd;
        logic      start_cmd;
        out_item_t r;
        dir = DIR_STOP;
        sc = ST_IDLE;
        sv = 1'b0;
        stop_cmd = it.cmd_valid && it.cmd_byte == CMD_STOP;
        start_cmd = it.cmd_valid && it.cmd_byte == CMD_START;
        case (ph)
            PH_IDLE: begin
                if (!it.cmd_valid) begin
                    sv = 1'b1;
                end else if (start_cmd) begin
                    led = 1'b1;
                    ph = PH_DOWN;
                end
            end
            PH_DOWN, PH_UP, PH_DWELL, PH_FINAL: begin
                if (!it.cmd_valid) begin
                    sv = 1'b1;
                    sc = ST_RUNNING;
                end
                if (stop_cmd) begin
                    ph = PH_STOPPING;
                    stops_taken++;
                end else begin
                    case (ph)
                        PH_DOWN: begin
                            if (it.lower_hit) begin
                                ang = cycle_deg(cyc);
                                ph = PH_UP;
                            end else begin
                                dir = DIR_DOWN;
                            end
                        end
                        PH_UP: begin
                            if (it.upper_hit) begin
                                dwc = 16'd0;
                                ph = PH_DWELL;
                            end else begin
                                dir = DIR_UP;
                            end
                        end
                        PH_DWELL: begin
                            if (it.ms_tick) begin
                                if (dwc >= c_dwell) begin
                                    if (cyc >= SEQ_CYCLES) begin
                                        ph = PH_FINAL;
                                    end else begin
                                        cyc = cyc + 3'd1;
                                        ph = PH_DOWN;
                                    end
                                end else begin
                                    dwc = dwc + 16'd1;
                                end
                            end
                        end
                        default: begin
                            if (it.lower_hit) begin
                                ang = home_clip();
                                ph = PH_COMPLETE;
                                runs_done++;
                            end else begin
                                dir = DIR_DOWN;
                            end
                        end
                    endcase
                end
            end
            PH_STOPPING: begin
                led = 1'b0;
                if (it.lower_hit) begin
                    ang = home_clip();
                    ph = PH_IDLE;
                end else begin
                    dir = DIR_DOWN;
                end
            end
            PH_COMPLETE: begin
                sv = 1'b1;
                sc = ST_COMPLETE;
                cyc = 3'd1;
                led = 1'b0;
                ph = PH_IDLE;
            end
            default: begin
                ph = PH_IDLE;
            end
        endcase
        r.motor_dir = dir;
        r.pwm_duty = (dir != DIR_STOP) ? c_duty : 8'd0;
        r.servo_angle = ang;
        r.busy_led = led;
        r.status_valid = sv;
        r.status_code = sc;
        r.phase_now = ph;
        return r;
    endfunction

    function automatic in_item_t sample(logic cv, logic [7:0] cb, logic lo, logic hi,
                                        logic tk);
        in_item_t it;
        it.cmd_valid = cv;
        it.cmd_byte = cb;
        it.lower_hit = lo;
        it.upper_hit = hi;
        it.ms_tick = tk;
        return it;
    endfunction

    // random period: mostly switch and tick activity, rare commands
    function automatic in_item_t rand_sample(int stop_pm);
        in_item_t it;
        int r;
        it = sample(1'b0, 8'($urandom), $urandom_range(0, 99) < 30,
                    $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 55);
        r = $urandom_range(0, 999);
        if (r < stop_pm) begin
            it.cmd_valid = 1'b1;
            it.cmd_byte = CMD_STOP;
        end else if (r < stop_pm + 30) begin
            it.cmd_valid = 1'b1;
            if (it.cmd_byte == CMD_START || it.cmd_byte == CMD_STOP)
                it.cmd_byte = it.cmd_byte | 8'hF0;
        end else if (r < stop_pm + 40) begin
            it.cmd_valid = 1'b1;
            it.cmd_byte = CMD_START;
        end
        return it;
    endfunction

    // up to three random periods, then a start followed by a random run body, sometimes cut by a stop
    function automatic int push_episode();
        int n_idle;
        int body;
        int cut;
        int k;
        n_idle = $urandom_range(0, 3);
        body = $urandom_range(50, 140);
        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, body - 1) : -1;
        for (k = 0; k < n_idle; k++)
            sample_q.push_back(rand_sample(0));
        sample_q.push_back(sample(1'b1, CMD_START, 1'($urandom), 1'($urandom),
                                  1'($urandom)));
        for (k = 0; k < body; k++) begin
            if (k == cut)
                sample_q.push_back(sample(1'b1, CMD_STOP, 1'($urandom), 1'($urandom),
                                          1'($urandom)));
            else
                sample_q.push_back(rand_sample(4));
        end
        return n_idle + 1 + body;
    endfunction

    function automatic void check_field(string name, int unsigned want_v,
                                        int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     want_v, got_v);
            fail_count++;
        end
    endfunction

    // sender: one item from the pending queue, then a drawn gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                report_q.push_back(advance_sequencer(cur_sample));
                samples_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    s_tvalid <= 1'b0;
                    send_wait--;
                end else if (sample_q.size() > 0) begin
                    cur_sample = sample_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= IN_TDATA_W'(cur_sample);
                    send_wait = calm ? 0 : $urandom_range(0, 8);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: compare each report, then stall for a drawn number of cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);
                reports_seen++;
                if (report_q.size() == 0) begin
                    $display("%0t: report with none expected, actual %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = report_q.pop_front();
                    check_field("motor_dir", want.motor_dir, got.motor_dir);
                    check_field("pwm_duty", want.pwm_duty, got.pwm_duty);
                    check_field("servo_angle", want.servo_angle, got.servo_angle);
                    check_field("busy_led", want.busy_led, got.busy_led);
                    check_field("status_valid", want.status_valid, got.status_valid);
                    check_field("status_code", want.status_code, got.status_code);
                    check_field("phase_now", want.phase_now, got.phase_now);
                end
                recv_wait = calm ? 0 : $urandom_range(0, 8);
            end
            if (recv_wait > 0) begin
                m_tready <= 1'b0;
                recv_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
                     report_q.size());
            $display("lift_servo_cycle_sequencer_tb: FAIL");
            $finish;
        end
    end

    task automatic drain();
        while (sample_q.size() > 0 || s_tvalid || report_q.size() > 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_DWELL_MS:   c_dwell = val;
            REG_MOTOR_DUTY: c_duty = val[7:0];
            default:        c_home = val[7:0];
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // upper bits of the 8-bit registers get noise, the block must drop them
    task automatic set_regs(logic [15:0] dwell, logic [7:0] duty, logic [7:0] home);
        write_reg(REG_DWELL_MS, dwell);
        write_reg(REG_MOTOR_DUTY, {8'($urandom), duty});
        write_reg(REG_HOME_ANGLE, {8'($urandom), home});
        settings_used++;
        @(negedge aclk);
    endtask

    initial begin
        int p;
        int added;
        int c;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: idle with bad commands, start, stop mid-descent
        sample_q.push_back(sample(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        sample_q.push_back(sample(1'b1, 8'hFF, 1'b1, 1'b1, 1'b1));
        sample_q.push_back(sample(1'b1, CMD_STOP, 1'b0, 1'b0, 1'b0));
        sample_q.push_back(sample(1'b1, CMD_START, 1'b0, 1'b0, 1'b0));
        sample_q.push_back(sample(1'b0, 8'h00, 1'b0, 1'b1, 1'b1));
        sample_q.push_back(sample(1'b1, CMD_STOP, 1'b0, 1'b0, 1'b0));
        sample_q.push_back(sample(1'b1, CMD_START, 1'b0, 1'b0, 1'b0));
        sample_q.push_back(sample(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
        drain();

        // zero dwell, full duty, home at the limit: one complete run
        set_regs(16'd0, 8'd255, 8'd180);
        sample_q.push_back(sample(1'b1, CMD_START, 1'b1, 1'b1, 1'b1));
        sample_q.push_back(sample(1'b1, 8'd7, 1'b0, 1'b0, 1'b0));
        sample_q.push_back(sample(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
        sample_q.push_back(sample(1'b1, CMD_START, 1'b0, 1'b0, 1'b1));
        sample_q.push_back(sample(1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
        sample_q.push_back(sample(1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
        sample_q.push_back(sample(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
        for (c = 2; c <= SEQ_CYCLES; c++) begin
            sample_q.push_back(sample(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
            sample_q.push_back(sample(1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
            sample_q.push_back(sample(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
        end
        sample_q.push_back(sample(1'b0, 8'h00, 1'b0, 1'b1, 1'b1));
        sample_q.push_back(sample(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
        sample_q.push_back(sample(1'b1, CMD_STOP, 1'b1, 1'b1, 1'b1));
        sample_q.push_back(sample(1'b1, 8'h00, 1'b0, 1'b0, 1'b0));
        drain();

        for (p = 0; p < 6; p++) begin
            case (p)
                0: set_regs(16'd0, 8'd0, 8'd0);
                1: set_regs(16'hFFFF, 8'd255, 8'd180);
                2: set_regs(16'd2, 8'd128, 8'd255);
                3: set_regs(16'd1, 8'($urandom), 8'd181);
                4: set_regs(16'($urandom_range(0, 4)), 8'($urandom), 8'($urandom));
                default: set_regs(16'd3, 8'd200, 8'd90);
            endcase
            calm = ($urandom_range(0, 3) == 0);
            added = 0;
            while (added < 275)
                added += push_episode();
            drain();
        end

        calm = 1'b0;
        if (report_q.size() != 0) begin
            $display("%0t: %0d expected reports never arrived", $time, report_q.size());
            fail_count++;
        end
        $display("checked %0d reports from %0d samples under %0d register settings",
                 reports_seen, samples_sent, settings_used);
        $display("runs completed %0d, stop commands taken %0d", runs_done, stops_taken);
        if (fail_count == 0)
            $display("lift_servo_cycle_sequencer_tb: PASS");
        else
            $display("lift_servo_cycle_sequencer_tb: FAIL");
        $finish;
    end

endmodule
